// ===== rtl/rpc_frame_deframer_macros.svh =====
// assertion macros for the rpc frame deframer
// included by the modules that carry assertions
`ifndef RPC_FRAME_DEFRAMER_MACROS_SVH
`define RPC_FRAME_DEFRAMER_MACROS_SVH

// condition implies consequence in the same cycle
`define RFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfd check failed");

// condition implies consequence in the next cycle
`define RFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfd check failed");

`endif

// ===== rtl/rfd_pkg.sv =====
// shared types and codes of the rpc frame deframer
// no dependencies
package rfd_pkg;

   // result kinds
   localparam logic [2:0] KIND_ID       = 3'd0;
   localparam logic [2:0] KIND_METHOD   = 3'd1;
   localparam logic [2:0] KIND_INFO     = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
   localparam logic [2:0] KIND_CHECKSUM = 3'd4;
   localparam logic [2:0] KIND_END      = 3'd5;

   // frame end status
   localparam logic [1:0] STAT_GOOD     = 2'd0;
   localparam logic [1:0] STAT_MISMATCH = 2'd1;
   localparam logic [1:0] STAT_LAYOUT   = 2'd2;

   // register indexes
   localparam logic CSR_START = 1'b0;
   localparam logic CSR_END   = 1'b1;

   // smallest legal frame: start, end and 24 header/checksum bytes
   localparam int MIN_FRAME = 2 + 24;
   // results kept per input item
   localparam int RES_CAP = 64;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         byte_value;
      logic [1:0]         frame_status;
      logic signed [31:0] error_code;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic step;
      logic from_input;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic rescan;
      logic replay_end;
      logic out_free;
      logic held_valid;
   } dp_status_type;

endpackage

// ===== rtl/rfd_if.sv =====
// stream interfaces of the rpc frame deframer
// depends on nothing but the port widths of the item fields
interface rfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic [7:0]         byte_value;
   logic [1:0]         frame_status;
   logic signed [31:0] error_code;
   logic               last;
   modport source (output valid, output kind, output byte_value, output frame_status,
                   output error_code, output last, input ready);
   modport sink (input valid, input kind, input byte_value, input frame_status,
                 input error_code, input last, output ready);
endinterface

// ===== rtl/rfd_ctrl.sv =====
// controller of the rpc frame deframer: input, replay and flush sequencing
// depends on rfd_pkg
module rfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rfd_pkg::dp_status_type status,
   output rfd_pkg::dp_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.step       = 1'b0;
      cmd.from_input = (state_ff == S_IDLE);
      cmd.flush      = 1'b0;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               cmd.step = 1'b1;
               if (status.rescan) state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.rescan) state_in = S_READ;
               else if (status.replay_end) state_in = S_FLUSH;
               else state_in = S_READ;
            end
         end
         S_FLUSH: begin
            if (!status.held_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== rtl/rfd_datapath.sv =====
// datapath of the rpc frame deframer: frame store, parser registers, result stages
// depends on rfd_pkg and rpc_frame_deframer_macros.svh
`include "rpc_frame_deframer_macros.svh"

module rfd_datapath #(
   parameter int MAX_FRAME = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rfd_pkg::dp_cmd_type    cmd,
   output rfd_pkg::dp_status_type status,
   input  logic [7:0]             req_byte,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [7:0]             csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rfd_pkg::rsp_item_type  rsp_data
);

   localparam int PW = $clog2(MAX_FRAME);
   localparam int FW = $clog2(MAX_FRAME + 1);
   localparam int CW = $clog2(rfd_pkg::RES_CAP + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(MAX_FRAME - 1);
   localparam logic [FW-1:0] HDR_BYTES = FW'(4);
   localparam logic [FW-1:0] MIN_LEN = FW'(rfd_pkg::MIN_FRAME);

   localparam logic [3:0] PH_HUNT    = 4'd0;
   localparam logic [3:0] PH_LEN     = 4'd1;
   localparam logic [3:0] PH_IDLEN   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_METHLEN = 4'd4;
   localparam logic [3:0] PH_METH    = 4'd5;
   localparam logic [3:0] PH_ERRC    = 4'd6;
   localparam logic [3:0] PH_INFOLEN = 4'd7;
   localparam logic [3:0] PH_INFO    = 4'd8;
   localparam logic [3:0] PH_PAY     = 4'd9;
   localparam logic [3:0] PH_CKSUM   = 4'd10;
   localparam logic [3:0] PH_SKIP    = 4'd11;
   localparam logic [3:0] PH_END     = 4'd12;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   logic [7:0]    mem [MAX_FRAME];
   logic [7:0]    rd_data_ff;
   logic [7:0]    start_mark_ff, end_mark_ff;
   logic [PW-1:0] wp_ff, rp_ff, base_ff, base_in;
   logic [3:0]    phase_ff, phase_in;
   logic [FW-1:0] fill_ff, fill_in, len_ff, len_in, rem_ff, rem_in, sum_ff, sum_in;
   logic [31:0]   shift_ff, shift_in, code_ff, code_in;
   logic [CW-1:0] cnt_ff;
   logic          out_v_ff, held_v_ff;
   rfd_pkg::rsp_item_type out_q, held_q, res;

   logic [7:0]    b;
   logic [PW-1:0] cur_addr;
   logic          emit, rescan, emit_ok, direct;
   logic [FW-1:0] fill_inc, rem_dec, sum_new;
   logic [31:0]   v;
   logic [32:0]   len33;

   assign b        = cmd.from_input ? req_byte : rd_data_ff;
   assign cur_addr = cmd.from_input ? wp_ff : rp_ff;
   assign fill_inc = (fill_ff < FW'(MAX_FRAME)) ? fill_ff + 1'b1 : fill_ff;
   assign rem_dec  = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
   assign v        = {shift_ff[23:0], b};
   assign len33    = 33'(len_ff);

   // parser step for one byte
   always_comb begin
      phase_in = phase_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      sum_in   = sum_ff;
      code_in  = code_ff;
      base_in  = base_ff;
      sum_new  = sum_ff;
      emit     = 1'b0;
      rescan   = 1'b0;
      res      = '0;
      if (phase_ff == PH_HUNT) begin
         if (b == start_mark_ff) begin
            base_in  = cur_addr;
            fill_in  = FW'(1);
            phase_in = PH_LEN;
            rem_in   = HDR_BYTES;
         end
      end else begin
         fill_in = fill_inc;
         if (phase_ff != PH_LEN && fill_inc == len_ff) begin
            // byte at the end position closes the frame
            emit     = 1'b1;
            res.kind = rfd_pkg::KIND_END;
            phase_in = PH_HUNT;
            fill_in  = '0;
            if (b != end_mark_ff) begin
               res.frame_status = rfd_pkg::STAT_MISMATCH;
               rescan           = 1'b1;
            end else if (phase_ff == PH_END) begin
               res.frame_status = rfd_pkg::STAT_GOOD;
               res.error_code   = code_ff;
            end else begin
               res.frame_status = rfd_pkg::STAT_LAYOUT;
            end
         end else begin
            unique case (phase_ff) inside
               PH_LEN, PH_IDLEN, PH_METHLEN, PH_ERRC, PH_INFOLEN: begin
                  shift_in = v;
                  rem_in   = rem_dec;
                  if (rem_dec == '0) begin
                     unique case (phase_ff)
                        PH_LEN: begin
                           len_in = FW'(v);
                           if (v[31] || v < 32'(rfd_pkg::MIN_FRAME) ||
                               v > 32'(MAX_FRAME)) begin
                              phase_in = PH_HUNT;
                              fill_in  = '0;
                              rescan   = 1'b1;
                           end else begin
                              phase_in = PH_IDLEN;
                              rem_in   = HDR_BYTES;
                           end
                        end
                        PH_IDLEN: begin
                           if (v[31] || 33'(v) + 33'd10 >= len33) begin
                              phase_in = PH_SKIP;
                              rem_in   = '0;
                           end else begin
                              sum_in   = FW'(v);
                              phase_in = (v != '0) ? PH_ID : PH_METHLEN;
                              rem_in   = (v != '0) ? FW'(v) : HDR_BYTES;
                           end
                        end
                        PH_METHLEN: begin
                           if (v[31] || 33'(v) + 33'(sum_ff) + 33'd18 >= len33) begin
                              phase_in = PH_SKIP;
                              rem_in   = '0;
                           end else begin
                              sum_in   = sum_ff + FW'(v);
                              phase_in = (v != '0) ? PH_METH : PH_ERRC;
                              rem_in   = (v != '0) ? FW'(v) : HDR_BYTES;
                           end
                        end
                        PH_ERRC: begin
                           code_in  = v;
                           phase_in = PH_INFOLEN;
                           rem_in   = HDR_BYTES;
                        end
                        default: begin
                           if (v[31] || 33'(rfd_pkg::MIN_FRAME) + 33'(sum_ff) + 33'(v) >
                               len33) begin
                              phase_in = PH_SKIP;
                              rem_in   = '0;
                           end else begin
                              sum_new = sum_ff + FW'(v);
                              sum_in  = sum_new;
                              if (v != '0) begin
                                 phase_in = PH_INFO;
                                 rem_in   = FW'(v);
                              end else if (len_ff - MIN_LEN - sum_new != '0) begin
                                 phase_in = PH_PAY;
                                 rem_in   = len_ff - MIN_LEN - sum_new;
                              end else begin
                                 phase_in = PH_CKSUM;
                                 rem_in   = HDR_BYTES;
                              end
                           end
                        end
                     endcase
                  end
               end
               PH_ID, PH_METH, PH_INFO, PH_PAY, PH_CKSUM: begin
                  // field byte goes out as it arrives
                  emit           = 1'b1;
                  res.byte_value = b;
                  rem_in         = rem_dec;
                  unique case (phase_ff)
                     PH_ID:   res.kind = rfd_pkg::KIND_ID;
                     PH_METH: res.kind = rfd_pkg::KIND_METHOD;
                     PH_INFO: res.kind = rfd_pkg::KIND_INFO;
                     PH_PAY:  res.kind = rfd_pkg::KIND_PAYLOAD;
                     default: res.kind = rfd_pkg::KIND_CHECKSUM;
                  endcase
                  if (rem_dec == '0) begin
                     unique case (phase_ff)
                        PH_ID: begin
                           phase_in = PH_METHLEN;
                           rem_in   = HDR_BYTES;
                        end
                        PH_METH: begin
                           phase_in = PH_ERRC;
                           rem_in   = HDR_BYTES;
                        end
                        PH_INFO: begin
                           if (len_ff - MIN_LEN - sum_ff != '0) begin
                              phase_in = PH_PAY;
                              rem_in   = len_ff - MIN_LEN - sum_ff;
                           end else begin
                              phase_in = PH_CKSUM;
                              rem_in   = HDR_BYTES;
                           end
                        end
                        PH_PAY: begin
                           phase_in = PH_CKSUM;
                           rem_in   = HDR_BYTES;
                        end
                        default: begin
                           phase_in = PH_END;
                           rem_in   = '0;
                        end
                     endcase
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign emit_ok = emit && (cmd.from_input || cnt_ff < CW'(rfd_pkg::RES_CAP));
   assign direct  = cmd.from_input && !rescan;

   assign status.rescan     = rescan;
   assign status.replay_end = (ptr_inc(rp_ff) == wp_ff);
   assign status.out_free   = !out_v_ff || rsp_ready;
   assign status.held_valid = held_v_ff;

   // frame store: input bytes written, replay read registered
   always_ff @(posedge clock) begin
      if (cmd.step && cmd.from_input) mem[wp_ff] <= b;
      rd_data_ff <= mem[rp_ff];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_mark_ff <= 8'd2;
         end_mark_ff   <= 8'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            rfd_pkg::CSR_START: start_mark_ff <= csr_wdata;
            rfd_pkg::CSR_END:   end_mark_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // parser state and pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         fill_ff  <= '0;
         len_ff   <= '0;
         shift_ff <= '0;
         rem_ff   <= '0;
         sum_ff   <= '0;
         code_ff  <= '0;
         base_ff  <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
         cnt_ff   <= '0;
      end else if (cmd.step) begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
         sum_ff   <= sum_in;
         code_ff  <= code_in;
         base_ff  <= base_in;
         if (cmd.from_input) wp_ff <= ptr_inc(wp_ff);
         if (rescan) rp_ff <= ptr_inc(base_ff);
         else if (!cmd.from_input) rp_ff <= ptr_inc(rp_ff);
         if (cmd.from_input) cnt_ff <= emit ? CW'(1) : '0;
         else if (emit_ok) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // output register and holding slot valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         held_v_ff <= 1'b0;
      end else begin
         if (rsp_ready) out_v_ff <= 1'b0;
         if (cmd.step && emit_ok) begin
            if (direct) out_v_ff <= 1'b1;
            else begin
               if (held_v_ff) out_v_ff <= 1'b1;
               held_v_ff <= 1'b1;
            end
         end
         if (cmd.flush && held_v_ff) begin
            out_v_ff  <= 1'b1;
            held_v_ff <= 1'b0;
         end
      end
   end

   // output and holding slot payload
   always_ff @(posedge clock) begin
      if (cmd.step && emit_ok) begin
         if (direct) begin
            out_q      <= res;
            out_q.last <= 1'b1;
         end else begin
            if (held_v_ff) begin
               out_q      <= held_q;
               out_q.last <= 1'b0;
            end
            held_q <= res;
         end
      end
      if (cmd.flush && held_v_ff) begin
         out_q      <= held_q;
         out_q.last <= 1'b1;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_q;

   `RFD_ASSERT_IMP(a_len_range, clock, reset, (phase_ff != PH_HUNT) && (phase_ff != PH_LEN), (len_ff >= MIN_LEN) && (len_ff <= FW'(MAX_FRAME)))
   `RFD_ASSERT_IMP(a_fill_below_len, clock, reset, (phase_ff != PH_HUNT) && (phase_ff != PH_LEN), fill_ff < len_ff)
   `RFD_ASSERT_NXT(a_flush_last, clock, reset, cmd.flush && held_v_ff, out_v_ff && out_q.last)

endmodule

// ===== rtl/rpc_frame_deframer.sv =====
// top level of the rpc frame deframer
// depends on rfd_pkg, rfd_if, rfd_ctrl and rfd_datapath
//
// Takes one received byte per cycle while the output register is free and no
// replay runs, hunts for the start byte and emits the field bytes of each
// frame tagged by kind, then a frame end result with status and error code;
// last marks the final result of an input byte. After a byte that causes no
// rescan the next byte can follow at once. A bad length or a wrong end byte
// makes the block replay the buffered frame bytes after the start byte from
// the frame store, each replayed byte read from the store, then parsed, and
// the final result then released; the input is not ready meanwhile. The frame
// store holds MAX_FRAME bytes as a ring and needs no clearing after reset.
module rpc_frame_deframer #(
   parameter int MAX_FRAME = 64
) (
   input  logic         clock,
   input  logic         reset,
   rfd_req_if.sink      req_ch,
   rfd_rsp_if.source    rsp_ch,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   rfd_pkg::dp_cmd_type    cmd;
   rfd_pkg::dp_status_type status;
   rfd_pkg::rsp_item_type  rsp_data;
   logic                   rsp_valid;

   // sequencing
   rfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // parser and storage
   rfd_datapath #(.MAX_FRAME(MAX_FRAME)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_byte  (req_ch.rx_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.kind         = rsp_data.kind;
   assign rsp_ch.byte_value   = rsp_data.byte_value;
   assign rsp_ch.frame_status = rsp_data.frame_status;
   assign rsp_ch.error_code   = rsp_data.error_code;
   assign rsp_ch.last         = rsp_data.last;

endmodule

// ===== test/tb_rpc_frame_deframer.sv =====
// self-checking testbench of the rpc frame deframer
// depends on rfd_pkg, rfd_if and rpc_frame_deframer
`timescale 1ns / 100ps

module tb_rpc_frame_deframer;
   import rfd_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int REPLAY_SZ   = STORE_DEPTH + 2;
   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE      = 200;

   typedef enum int {
      PH_HUNT, PH_LEN, PH_IDLEN, PH_ID, PH_METHLEN, PH_METH, PH_ERRC,
      PH_INFOLEN, PH_INFO, PH_PAY, PH_CKSUM, PH_SKIP, PH_END
   } parse_phase_type;

   typedef enum int {FR_GOOD, FR_BAD_END, FR_LAYOUT, FR_BAD_LEN} frame_variant_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_START;
   logic [7:0] csr_wdata = 8'd0;

   rfd_req_if req_if ();
   rfd_rsp_if rsp_if ();

   rpc_frame_deframer uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // deframer shadow state
   logic [7:0]      shadow_store [STORE_DEPTH];
   int unsigned     shadow_fill;
   parse_phase_type shadow_phase;
   int unsigned     shadow_len;
   logic [31:0]     shadow_shift;
   int unsigned     shadow_remain;
   int unsigned     shadow_strsum;
   logic [31:0]     shadow_err;
   logic [7:0]      start_byte;
   logic [7:0]      end_byte;

   rsp_item_type byte_results [$];
   rsp_item_type pending_fields [$];
   logic [7:0]   tx_bytes [$];

   int errors;
   int bytes_sent;
   int frames_built;
   int results_seen;
   int idle_cycles;
   bit calm_tx;
   bit calm_rx;
   int tx_gap;
   int rx_gap;

   function automatic void note_result(logic [2:0] k, logic [7:0] v, logic [1:0] st,
                                       logic [31:0] code);
      rsp_item_type r;
      if (byte_results.size() >= RES_CAP) return;
      r.kind = k;
      r.byte_value = v;
      r.frame_status = st;
      r.error_code = code;
      r.last = 1'b0;
      byte_results.push_back(r);
   endfunction

   function automatic void go_phase(parse_phase_type ph, int unsigned n);
      shadow_phase = ph;
      shadow_remain = n;
   endfunction

   function automatic void enter_payload();
      int unsigned n;
      n = shadow_len - MIN_FRAME - shadow_strsum;
      if (n > 0) go_phase(PH_PAY, n);
      else go_phase(PH_CKSUM, 4);
   endfunction

   // parse one byte; returns 1 when the buffered frame must be replayed
   function automatic bit parse_byte(logic [7:0] b);
      int unsigned     pos;
      logic [31:0]     v;
      logic [1:0]      st;
      logic [2:0]      k;
      parse_phase_type ph;
      if (shadow_phase == PH_HUNT) begin
         if (b == start_byte) begin
            shadow_store[0] = b;
            shadow_fill = 1;
            go_phase(PH_LEN, 4);
         end
         return 1'b0;
      end
      if (shadow_fill < STORE_DEPTH) begin
         shadow_store[shadow_fill] = b;
         shadow_fill++;
      end
      pos = shadow_fill - 1;
      // end position of the frame
      if (shadow_phase != PH_LEN && pos + 1 == shadow_len) begin
         if (b != end_byte) begin
            note_result(KIND_END, 8'd0, STAT_MISMATCH, 32'd0);
            shadow_phase = PH_HUNT;
            return 1'b1;
         end
         st = (shadow_phase == PH_END) ? STAT_GOOD : STAT_LAYOUT;
         note_result(KIND_END, 8'd0, st, st == STAT_GOOD ? shadow_err : 32'd0);
         shadow_phase = PH_HUNT;
         shadow_fill = 0;
         return 1'b0;
      end
      case (shadow_phase)
         PH_LEN, PH_IDLEN, PH_METHLEN, PH_ERRC, PH_INFOLEN: begin
            shadow_shift = {shadow_shift[23:0], b};
            if (shadow_remain > 0) shadow_remain--;
            if (shadow_remain != 0) return 1'b0;
            v = shadow_shift;
            if (shadow_phase == PH_LEN) begin
               shadow_len = v;
               if (v[31] || v < MIN_FRAME || v > STORE_DEPTH) begin
                  shadow_phase = PH_HUNT;
                  return 1'b1;
               end
               go_phase(PH_IDLEN, 4);
            end else if (shadow_phase == PH_IDLEN) begin
               if (v[31] || 64'd10 + v >= shadow_len) begin
                  go_phase(PH_SKIP, 0);
                  return 1'b0;
               end
               shadow_strsum = v;
               if (v > 0) go_phase(PH_ID, v);
               else go_phase(PH_METHLEN, 4);
            end else if (shadow_phase == PH_METHLEN) begin
               if (v[31] || 64'd18 + shadow_strsum + v >= shadow_len) begin
                  go_phase(PH_SKIP, 0);
                  return 1'b0;
               end
               shadow_strsum += v;
               if (v > 0) go_phase(PH_METH, v);
               else go_phase(PH_ERRC, 4);
            end else if (shadow_phase == PH_ERRC) begin
               shadow_err = v;
               go_phase(PH_INFOLEN, 4);
            end else begin
               if (v[31] || 64'd26 + shadow_strsum + v > shadow_len) begin
                  go_phase(PH_SKIP, 0);
                  return 1'b0;
               end
               shadow_strsum += v;
               if (v > 0) go_phase(PH_INFO, v);
               else enter_payload();
            end
            return 1'b0;
         end
         PH_ID, PH_METH, PH_INFO, PH_PAY, PH_CKSUM: begin
            ph = shadow_phase;
            k = ph == PH_ID ? KIND_ID : ph == PH_METH ? KIND_METHOD :
                ph == PH_INFO ? KIND_INFO : ph == PH_PAY ? KIND_PAYLOAD : KIND_CHECKSUM;
            note_result(k, b, STAT_GOOD, 32'd0);
            if (shadow_remain > 0) shadow_remain--;
            if (shadow_remain != 0) return 1'b0;
            if (ph == PH_ID) go_phase(PH_METHLEN, 4);
            else if (ph == PH_METH) go_phase(PH_ERRC, 4);
            else if (ph == PH_INFO) enter_payload();
            else if (ph == PH_PAY) go_phase(PH_CKSUM, 4);
            else go_phase(PH_END, 0);
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // one received byte, with replays of the buffered frame
   function automatic void predict_byte(logic [7:0] b);
      logic [7:0]  replay [REPLAY_SZ];
      int unsigned head;
      int unsigned n;
      logic [7:0]  cur;
      head = REPLAY_SZ - 1;
      replay[head] = b;
      byte_results.delete();
      while (head < REPLAY_SZ) begin
         cur = replay[head];
         head++;
         if (parse_byte(cur)) begin
            n = shadow_fill > 1 ? shadow_fill - 1 : 0;
            if (n > STORE_DEPTH - 1) n = STORE_DEPTH - 1;
            if (n > head) n = head;
            head -= n;
            for (int i = 0; i < n; i++) replay[head + i] = shadow_store[1 + i];
            shadow_fill = 0;
         end
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
      foreach (byte_results[i]) pending_fields.push_back(byte_results[i]);
   endfunction

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // stimulus construction
   function automatic void put32(ref logic [7:0] fr [$], input int idx, input logic [31:0] v);
      for (int i = 0; i < 4; i++) fr[idx + i] = v[31 - 8 * i -: 8];
   endfunction

   function automatic void add_frame(frame_variant_type variant);
      logic [7:0]  fr [$];
      int unsigned il, ml, nl, pl, room, flen;
      logic [31:0] code;
      int r;
      il = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      ml = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      nl = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      room = STORE_DEPTH - MIN_FRAME - il - ml - nl;
      if ($urandom_range(0, 7) == 0) pl = room;
      else pl = $urandom_range(0, room < 10 ? room : 10);
      flen = MIN_FRAME + il + ml + nl + pl;
      r = $urandom_range(0, 9);
      code = r == 0 ? 32'h8000_0000 : r == 1 ? 32'h7FFF_FFFF : $urandom;
      fr.push_back(start_byte);
      for (int i = 0; i < 4; i++) fr.push_back(8'd0);
      for (int i = 0; i < 4; i++) fr.push_back(8'd0);
      repeat (il) fr.push_back($urandom_range(0, 255));
      for (int i = 0; i < 4; i++) fr.push_back(8'd0);
      repeat (ml) fr.push_back($urandom_range(0, 255));
      for (int i = 0; i < 4; i++) fr.push_back(8'd0);
      for (int i = 0; i < 4; i++) fr.push_back(8'd0);
      repeat (nl + pl + 4) fr.push_back($urandom_range(0, 255));
      fr.push_back(end_byte);
      put32(fr, 1, flen);
      put32(fr, 5, il);
      put32(fr, 9 + il, ml);
      put32(fr, 13 + il + ml, code);
      put32(fr, 17 + il + ml, nl);
      case (variant)
         FR_BAD_END: fr[flen - 1] = end_byte ^ 8'($urandom_range(1, 255));
         FR_LAYOUT: begin
            case ($urandom_range(0, 3))
               0: put32(fr, 5, 32'h8000_0000 | $urandom);
               1: put32(fr, 5, flen - 10 + $urandom_range(0, 3));
               2: put32(fr, 9 + il, flen);
               default: put32(fr, 17 + il + ml, flen);
            endcase
            // now and then the end byte is wrong as well
            if ($urandom_range(0, 3) == 0) fr[flen - 1] = end_byte ^ 8'h5A;
         end
         FR_BAD_LEN: begin
            case ($urandom_range(0, 2))
               0: put32(fr, 1, $urandom_range(0, MIN_FRAME - 1));
               1: put32(fr, 1, $urandom_range(STORE_DEPTH + 1, 300));
               default: put32(fr, 1, 32'h8000_0000 | $urandom);
            endcase
         end
         default: ;
      endcase
      foreach (fr[i]) tx_bytes.push_back(fr[i]);
      frames_built++;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (tx_bytes.size() != 0 || req_if.valid || pending_fields.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [7:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_START) start_byte = value;
      else end_byte = value;
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int target);
      int base;
      int r;
      base = tx_bytes.size();
      while (tx_bytes.size() - base < target) begin
         repeat ($urandom_range(0, 3)) tx_bytes.push_back($urandom_range(0, 255));
         r = $urandom_range(0, 99);
         if (r < 55) add_frame(FR_GOOD);
         else if (r < 70) add_frame(FR_BAD_END);
         else if (r < 85) add_frame(FR_LAYOUT);
         else add_frame(FR_BAD_LEN);
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.rx_byte <= 8'd0;
         tx_gap = 0;
      end else begin
         if ($urandom_range(0, 149) == 0) calm_tx = ~calm_tx;
         if (!req_if.valid || req_if.ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_if.valid <= 1'b0;
            end else if (tx_bytes.size() > 0) begin
               req_if.valid <= 1'b1;
               req_if.rx_byte <= tx_bytes.pop_front();
               tx_gap = pick_gap(calm_tx);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_gap = 0;
      end else begin
         if ($urandom_range(0, 149) == 0) calm_rx = ~calm_rx;
         if (rx_gap > 0) begin
            rx_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_gap = pick_gap(calm_rx);
         end
      end
   end

   // monitor: predict on every accepted byte, then check the accepted result
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_byte(req_if.rx_byte);
            bytes_sent++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (pending_fields.size() == 0) begin
               errors++;
               $display("%0t: unexpected item kind=%0d byte=%02h status=%0d code=%0d last=%0d",
                        $time, rsp_if.kind, rsp_if.byte_value, rsp_if.frame_status,
                        rsp_if.error_code, rsp_if.last);
            end else begin
               want = pending_fields.pop_front();
               if (want.kind !== rsp_if.kind || want.byte_value !== rsp_if.byte_value ||
                   want.frame_status !== rsp_if.frame_status ||
                   want.error_code !== rsp_if.error_code || want.last !== rsp_if.last) begin
                  errors++;
                  $display("%0t: mismatch expected kind=%0d byte=%02h status=%0d code=%0d last=%0d",
                           $time, want.kind, want.byte_value, want.frame_status,
                           want.error_code, want.last);
                  $display("%0t:          actual   kind=%0d byte=%02h status=%0d code=%0d last=%0d",
                           $time, rsp_if.kind, rsp_if.byte_value, rsp_if.frame_status,
                           rsp_if.error_code, rsp_if.last);
               end
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("tb_rpc_frame_deframer: FAIL");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.rx_byte = 8'd0;
      rsp_if.ready = 1'b0;
      errors = 0;
      bytes_sent = 0;
      frames_built = 0;
      results_seen = 0;
      idle_cycles = 0;
      calm_tx = 1'b0;
      calm_rx = 1'b0;
      foreach (shadow_store[i]) shadow_store[i] = 8'd0;
      shadow_fill = 0;
      shadow_phase = PH_HUNT;
      shadow_len = 0;
      shadow_shift = 32'd0;
      shadow_remain = 0;
      shadow_strsum = 0;
      shadow_err = 32'd0;
      start_byte = 8'd2;
      end_byte = 8'd3;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // extremes while hunting, then the three kinds of bad length
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'hFF);
      tx_bytes.push_back(start_byte);
      tx_bytes.push_back(8'hFF); tx_bytes.push_back(8'hFF);
      tx_bytes.push_back(8'hFF); tx_bytes.push_back(8'hFF);
      tx_bytes.push_back(start_byte);
      tx_bytes.push_back(8'h00); tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'h00); tx_bytes.push_back(8'd25);
      tx_bytes.push_back(start_byte);
      tx_bytes.push_back(8'h00); tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'h00); tx_bytes.push_back(8'd65);
      wait_drained();

      // reset markers, then the extremes and a random pair
      run_phase(100);
      wait_drained();
      write_csr(CSR_START, 8'h00);
      write_csr(CSR_END, 8'hFF);
      run_phase(100);
      wait_drained();
      write_csr(CSR_START, 8'hFF);
      write_csr(CSR_END, 8'h00);
      run_phase(100);
      wait_drained();
      write_csr(CSR_START, $urandom_range(0, 255));
      write_csr(CSR_END, $urandom_range(0, 255));
      run_phase(100);
      wait_drained();

      if (pending_fields.size() != 0) begin
         errors++;
         $display("%0t: %0d expected items never arrived", $time, pending_fields.size());
      end
      $display("covered %0d bytes in %0d frames (good, bad end, layout, bad length)",
               bytes_sent, frames_built);
      $display("checked %0d result items over four marker settings", results_seen);
      if (errors == 0)
         $display("tb_rpc_frame_deframer: PASS");
      else
         $display("tb_rpc_frame_deframer: FAIL");
      $finish;
   end

endmodule
